/* src/ps2ms_pkg.sv */
// ----------------------------------------------------------------------------
// ps2ms_pkg
// shared types and constants for the ps/2 mouse packet event stack
// ----------------------------------------------------------------------------
package ps2ms_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DX_W   = 11;
  localparam int unsigned DY_W   = 6;
  localparam int unsigned BTN_W  = 3;

  // item kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_POLL = 1'b1;

  // packet byte index
  typedef enum logic [1:0] {
    PH_STATUS = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2,
    PH_SPARE  = 2'd3
  } phase_t;

  // one stored event
  typedef struct packed {
    logic signed [DX_W-1:0] dx;
    logic signed [DY_W-1:0] dy;
    logic [BTN_W-1:0]       btn;
  } entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic data_go;
    logic pop_go;
    logic load_poll;
  } cmd_t;

endpackage

/* src/ps2_mouse_packet_event_stack.sv */
// ----------------------------------------------------------------------------
// ps2_mouse_packet_event_stack
// groups ps/2 mouse bytes into three-byte packets, accumulates position and
// keeps decoded events on a lifo stack that poll transactions pop
// ----------------------------------------------------------------------------
// data byte: loads the result register directly; one per cycle unless stalled
// poll: registered read of the stack memory, then the result register; no new
//   transaction is taken while the poll reads
// reset: synchronous active low; clears packet phase, positions and stack
//   count, stack contents are not cleared
module ps2_mouse_packet_event_stack #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_kind,
  input  logic [ps2ms_pkg::BYTE_W-1:0]        in_data_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_event_valid,
  output logic signed [ps2ms_pkg::DX_W-1:0]   out_event_dx,
  output logic signed [ps2ms_pkg::DY_W-1:0]   out_event_dy,
  output logic                                out_event_left,
  output logic                                out_event_right,
  output logic                                out_event_middle,
  output logic signed [ps2ms_pkg::BYTE_W-1:0] out_position_x,
  output logic signed [ps2ms_pkg::BYTE_W-1:0] out_position_y,
  output logic                                out_events_pending,
  output logic                                out_event_dropped
);

  ps2ms_pkg::cmd_t cmd;

  ps2ms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ps2ms_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_data_byte       (in_data_byte),
    .out_event_valid    (out_event_valid),
    .out_event_dx       (out_event_dx),
    .out_event_dy       (out_event_dy),
    .out_event_left     (out_event_left),
    .out_event_right    (out_event_right),
    .out_event_middle   (out_event_middle),
    .out_position_x     (out_position_x),
    .out_position_y     (out_position_y),
    .out_events_pending (out_events_pending),
    .out_event_dropped  (out_event_dropped)
  );

endmodule

/* src/ps2ms_ctrl.sv */
// ----------------------------------------------------------------------------
// ps2ms_ctrl
// handshake controller: accepts transactions, sequences the stack read and
// owns the output valid flag
// ----------------------------------------------------------------------------
module ps2ms_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_kind,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output ps2ms_pkg::cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  assign cmd.data_go   = accept && (in_kind == ps2ms_pkg::KIND_DATA);
  assign cmd.pop_go    = accept && (in_kind == ps2ms_pkg::KIND_POLL);
  assign cmd.load_poll = (state_r == S_READ);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (cmd.data_go) begin
          out_valid_nxt = 1'b1;
        end else if (cmd.pop_go) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* src/ps2ms_dp.sv */
// ----------------------------------------------------------------------------
// ps2ms_dp
// datapath: packet assembly, delta arithmetic, position accumulators,
// event stack memory and result register
// ----------------------------------------------------------------------------
module ps2ms_dp #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ps2ms_pkg::cmd_t                     cmd,
  input  logic [ps2ms_pkg::BYTE_W-1:0]        in_data_byte,
  output logic                                out_event_valid,
  output logic signed [ps2ms_pkg::DX_W-1:0]   out_event_dx,
  output logic signed [ps2ms_pkg::DY_W-1:0]   out_event_dy,
  output logic                                out_event_left,
  output logic                                out_event_right,
  output logic                                out_event_middle,
  output logic signed [ps2ms_pkg::BYTE_W-1:0] out_position_x,
  output logic signed [ps2ms_pkg::BYTE_W-1:0] out_position_y,
  output logic                                out_events_pending,
  output logic                                out_event_dropped
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  ps2ms_pkg::entry_t mem [STACK_DEPTH];

  ps2ms_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]        status_r, status_nxt;
  logic [7:0]        second_r, second_nxt;
  logic [7:0]        acc_x_r, acc_x_nxt;
  logic [7:0]        acc_y_r, acc_y_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     count_dec;
  logic              full;
  logic              push;
  logic              popped_r;
  ps2ms_pkg::entry_t rd_data_r;
  ps2ms_pkg::entry_t new_ev;

  logic signed [8:0] b1, b2, dy_raw, dy_adj, dx_raw;
  logic signed [8:0] dy_q;

  logic                                ev_valid_r;
  logic signed [ps2ms_pkg::DX_W-1:0]   ev_dx_r;
  logic signed [ps2ms_pkg::DY_W-1:0]   ev_dy_r;
  logic [ps2ms_pkg::BTN_W-1:0]         ev_btn_r;
  logic                                dropped_r;
  logic                                pending_r;

  // delta arithmetic
  assign b1     = {second_r[7], second_r};
  assign b2     = {in_data_byte[7], in_data_byte};
  assign dy_raw = status_r[4] ? b1 : -b1;
  assign dy_adj = dy_raw + (dy_raw[8] ? 9'sd7 : 9'sd0);
  assign dy_q   = dy_adj >>> 3;
  assign dx_raw = status_r[5] ? -b2 : b2;

  assign new_ev.dx  = {dx_raw, 2'b00};
  assign new_ev.dy  = dy_q[ps2ms_pkg::DY_W-1:0];
  assign new_ev.btn = status_r[ps2ms_pkg::BTN_W-1:0];

  assign full      = (count_r >= DEPTH_C);
  assign count_dec = count_r - CW'(1);
  assign push      = cmd.data_go && (phase_r != ps2ms_pkg::PH_STATUS)
                     && (phase_r != ps2ms_pkg::PH_SECOND) && !full;

  always_comb begin
    phase_nxt  = phase_r;
    status_nxt = status_r;
    second_nxt = second_r;
    acc_x_nxt  = acc_x_r;
    acc_y_nxt  = acc_y_r;
    count_nxt  = count_r;
    if (cmd.data_go) begin
      unique case (phase_r)
        ps2ms_pkg::PH_STATUS: begin
          status_nxt = in_data_byte;
          phase_nxt  = ps2ms_pkg::PH_SECOND;
        end
        ps2ms_pkg::PH_SECOND: begin
          second_nxt = in_data_byte;
          phase_nxt  = ps2ms_pkg::PH_THIRD;
        end
        default: begin
          acc_x_nxt = acc_x_r + new_ev.dx[7:0];
          acc_y_nxt = acc_y_r + dy_q[7:0];
          phase_nxt = ps2ms_pkg::PH_STATUS;
          if (!full) begin
            count_nxt = count_r + CW'(1);
          end
        end
      endcase
    end else if (cmd.pop_go && (count_r != '0)) begin
      count_nxt = count_dec;
    end
  end

  // stack memory
  always_ff @(posedge clk) begin
    if (push) begin
      mem[count_r[AW-1:0]] <= new_ev;
    end
    if (cmd.pop_go) begin
      rd_data_r <= mem[count_dec[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= ps2ms_pkg::PH_STATUS;
      status_r <= '0;
      second_r <= '0;
      acc_x_r  <= '0;
      acc_y_r  <= '0;
      count_r  <= '0;
      popped_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      status_r <= status_nxt;
      second_r <= second_nxt;
      acc_x_r  <= acc_x_nxt;
      acc_y_r  <= acc_y_nxt;
      count_r  <= count_nxt;
      if (cmd.pop_go) begin
        popped_r <= (count_r != '0);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.data_go) begin
      ev_valid_r <= 1'b0;
      ev_dx_r    <= '0;
      ev_dy_r    <= '0;
      ev_btn_r   <= '0;
      dropped_r  <= (phase_r != ps2ms_pkg::PH_STATUS)
                    && (phase_r != ps2ms_pkg::PH_SECOND) && full;
      pending_r  <= (count_nxt != '0);
    end else if (cmd.load_poll) begin
      ev_valid_r <= popped_r;
      ev_dx_r    <= popped_r ? rd_data_r.dx  : '0;
      ev_dy_r    <= popped_r ? rd_data_r.dy  : '0;
      ev_btn_r   <= popped_r ? rd_data_r.btn : '0;
      dropped_r  <= 1'b0;
      pending_r  <= (count_r != '0);
    end
  end

  assign out_event_valid    = ev_valid_r;
  assign out_event_dx       = ev_dx_r;
  assign out_event_dy       = ev_dy_r;
  assign out_event_left     = ev_btn_r[0];
  assign out_event_right    = ev_btn_r[1];
  assign out_event_middle   = ev_btn_r[2];
  assign out_position_x     = acc_x_r;
  assign out_position_y     = acc_y_r;
  assign out_events_pending = pending_r;
  assign out_event_dropped  = dropped_r;

endmodule

/* src/ps2ms_chk.sv */
// ----------------------------------------------------------------------------
// ps2ms_chk
// port-level checks for the ps/2 mouse packet event stack
// ----------------------------------------------------------------------------
module ps2ms_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                in_kind,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                out_event_valid,
  input logic signed [ps2ms_pkg::DX_W-1:0]   out_event_dx,
  input logic signed [ps2ms_pkg::DY_W-1:0]   out_event_dy,
  input logic                                out_event_left,
  input logic                                out_event_right,
  input logic                                out_event_middle,
  input logic signed [ps2ms_pkg::BYTE_W-1:0] out_position_x,
  input logic signed [ps2ms_pkg::BYTE_W-1:0] out_position_y,
  input logic                                out_events_pending,
  input logic                                out_event_dropped
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_dx)
      && $stable(out_event_dy) && $stable(out_position_x) && $stable(out_position_y))
    else $error("result changed while stalled");

  // no event means zero event fields
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_event_valid |-> out_event_dx == '0 && out_event_dy == '0
      && !out_event_left && !out_event_right && !out_event_middle)
    else $error("event fields set without an event");

  // a drop only happens with a full stack
  a_drop_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_dropped |-> out_events_pending && !out_event_valid)
    else $error("drop reported with empty stack or popped event");

  // an accepted poll is followed by in_ready low while the stack is read
  a_poll_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == ps2ms_pkg::KIND_POLL) |=> !in_ready)
    else $error("poll transaction not followed by a busy cycle");

  // dy stays within its range
  a_dy_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_dy >= -6'sd16 && out_event_dy <= 6'sd16)
    else $error("dy out of range");

endmodule

bind ps2_mouse_packet_event_stack ps2ms_chk u_ps2ms_chk (.*);
